[rtl/core/dmxswr_pkg.sv]
package dmxswr_pkg;

   // Default number of entries in the slot window store.
   localparam int WINDOW_DEPTH_DEF = 32;

   // DMX512 frame geometry.
   localparam int DMX_SLOTS     = 512;
   localparam int DMX_LAST_SLOT = 511;

   // Field widths.
   localparam int ACTION_W  = 2;
   localparam int BYTE_W    = 8;
   localparam int RIDX_W    = 5;
   localparam int START_W   = 9;
   localparam int LENGTH_W  = 6;
   localparam int COUNT_W   = 10;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 9;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START_ADDRESS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 1'd1;

   // Reset values of the configuration registers.
   localparam logic [START_W-1:0]  START_ADDRESS_RST = 9'd0;
   localparam logic [LENGTH_W-1:0] WINDOW_LENGTH_RST = 6'd32;

   // Request kinds carried in the input word.
   typedef enum logic [ACTION_W-1:0] {
      ACT_RX    = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   // Receive phases of the framer.
   typedef enum logic [1:0] {
      PH_STARTUP = 2'd0,
      PH_IDLE    = 2'd1,
      PH_BREAK   = 2'd2,
      PH_DATA    = 2'd3
   } phase_type;

   // One result word.
   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              updated;
      logic              frame_started;
      logic              value_changed;
      logic [4:0]        window_index;
      logic              slot_captured;
   } result_type;

endpackage

[rtl/core/dmxswr_store.sv]
module dmxswr_store #(
   parameter int WINDOW_DEPTH = dmxswr_pkg::WINDOW_DEPTH_DEF,
   parameter int IDX_W = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [IDX_W-1:0]              rd_addr,
   output logic [dmxswr_pkg::BYTE_W-1:0] rd_data,
   input  logic                          wr_en,
   input  logic [IDX_W-1:0]              wr_addr,
   input  logic [dmxswr_pkg::BYTE_W-1:0] wr_data
);
   import dmxswr_pkg::*;

   logic [BYTE_W-1:0] store_ff [WINDOW_DEPTH];

   // Slot values; the whole store is zeroed at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Single read port; the address is checked against the depth by the caller.
   assign rd_data = store_ff[rd_addr];

endmodule

[rtl/core/dmxswr_core.sv]
module dmxswr_core #(
   parameter int WINDOW_DEPTH = dmxswr_pkg::WINDOW_DEPTH_DEF,
   parameter int IDX_W = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step_en,
   input  dmxswr_pkg::action_type          action,
   input  logic [dmxswr_pkg::BYTE_W-1:0]   rx_byte,
   input  logic                            frame_error,
   input  logic [dmxswr_pkg::RIDX_W-1:0]   read_index,
   input  logic [dmxswr_pkg::START_W-1:0]  start_address,
   input  logic [dmxswr_pkg::LENGTH_W-1:0] window_length,
   output logic [IDX_W-1:0]                rd_addr,
   input  logic [dmxswr_pkg::BYTE_W-1:0]   rd_data,
   output logic                            wr_en,
   output logic [IDX_W-1:0]                wr_addr,
   output logic [dmxswr_pkg::BYTE_W-1:0]   wr_data,
   output dmxswr_pkg::result_type          result
);
   import dmxswr_pkg::*;

   localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(WINDOW_DEPTH);
   localparam logic [COUNT_W-1:0] SLOTS_CNT = COUNT_W'(DMX_SLOTS);

   phase_type            phase_ff, phase_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 updated_ff, updated_in;

   logic [COUNT_W-1:0]   start_ext;
   logic [COUNT_W-1:0]   length_ext;
   logic [COUNT_W-1:0]   length_lim;
   logic [COUNT_W-1:0]   offset;
   logic [COUNT_W-1:0]   ridx_ext;
   logic [COUNT_W-1:0]   count_inc;
   logic                 in_window;
   logic                 ridx_ok;
   logic                 is_data_slot;
   logic                 captured;
   logic                 changed;
   logic                 started;

   // Window membership: the length is limited to the store depth, and the slot
   // counter never passes the last slot while a frame is open.
   always_comb begin
      start_ext  = COUNT_W'(start_address);
      length_ext = COUNT_W'(window_length);
      length_lim = (length_ext > DEPTH_CNT) ? DEPTH_CNT : length_ext;
      offset     = count_ff - start_ext;
      in_window  = (count_ff >= start_ext) && (offset < length_lim);
      ridx_ext   = COUNT_W'(read_index);
      ridx_ok    = ridx_ext < DEPTH_CNT;
      count_inc  = count_ff + COUNT_W'(1);
   end

   // A character is a data slot when it arrives in an open frame without error.
   assign is_data_slot = (action == ACT_RX) && (phase_ff == PH_DATA) && !frame_error;

   // Store access: one read address serves both the compare and the read request.
   assign rd_addr  = (action == ACT_READ) ? ridx_ext[IDX_W-1:0] : offset[IDX_W-1:0];
   assign captured = is_data_slot && in_window;
   assign changed  = captured && (rd_data != rx_byte);
   assign wr_en    = step_en && changed;
   assign wr_addr  = offset[IDX_W-1:0];
   assign wr_data  = rx_byte;

   // Next phase and slot counter.
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      if (action == ACT_RX) begin
         case (phase_ff)
            PH_STARTUP: begin
               phase_in = PH_IDLE;
            end
            PH_BREAK: begin
               if (frame_error) begin
                  count_in = '0;
               end else if (rx_byte == '0) begin
                  phase_in = PH_DATA;
                  count_in = '0;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_DATA: begin
               if (frame_error) begin
                  phase_in = PH_BREAK;
                  count_in = '0;
               end else begin
                  count_in = count_inc;
                  if (count_inc >= SLOTS_CNT) begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            default: begin
               if (frame_error) begin
                  phase_in = PH_BREAK;
                  count_in = '0;
               end
            end
         endcase
      end
   end

   // Result fields and the sticky change flag.
   always_comb begin
      started    = (action == ACT_RX) && (phase_ff == PH_BREAK) && !frame_error &&
                   (rx_byte == '0);
      updated_in = updated_ff;
      case (action)
         ACT_RX: begin
            if (changed) begin
               updated_in = 1'b1;
            end
         end
         ACT_CLEAR: begin
            updated_in = 1'b0;
         end
         default: begin
            updated_in = updated_ff;
         end
      endcase
      result.slot_captured = captured;
      result.window_index  = captured ? offset[4:0] : 5'd0;
      result.value_changed = changed;
      result.frame_started = started;
      result.updated       = updated_in;
      result.read_data     = ((action == ACT_READ) && ridx_ok) ? rd_data : '0;
   end

   // Framer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_STARTUP;
         count_ff   <= '0;
         updated_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         updated_ff <= updated_in;
      end
   end

endmodule

[rtl/core/dmx512_slot_window_receiver.sv]
// DMX512 slot-window receiver.
// Request words carry one of three requests in req_tuser: a received UART
// character with its framing-error flag, a read of one window entry, or a
// clear of the sticky updated flag. Each request word yields exactly one
// response word on rsp_. Received characters follow the DMX512 framing: a
// framing error is a break, a zero start code opens a frame, and data slots
// inside the window set by start_address and window_length are stored.
// Configuration registers are written on the csr_ channel, which is always
// ready; write them only while no request is in flight.
// A response word becomes valid once its request word has passed the request
// register and then the response register. Throughput is one word per clock
// while rsp_tready is high; the store is a flop array read and written in
// the same cycle, so back-to-back slots see each other's writes.
// When rsp_tready is low the response holds, one more request is held in
// the request register, and req_tready falls until the response is taken.
// Reset is synchronous: it zeros the store, the slot counter and the
// updated flag, restores the register defaults and puts the framer into
// its startup phase, in which the first received character is dropped.
module dmx512_slot_window_receiver #(
   parameter int WINDOW_DEPTH = dmxswr_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // rx_byte, read_index
   input  logic [2:0]                        req_tuser,  // action, frame_error
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,  // slot_captured, window_index,
                                                         // value_changed, frame_started,
                                                         // updated, read_data
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dmxswr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dmxswr_pkg::CSR_DATA_W-1:0] csr_data
);
   import dmxswr_pkg::*;

   localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

   logic                 in_valid_ff;
   action_type           action_ff;
   logic [BYTE_W-1:0]    byte_ff;
   logic                 ferr_ff;
   logic [RIDX_W-1:0]    ridx_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff;
   logic [START_W-1:0]   start_ff;
   logic [LENGTH_W-1:0]  length_ff;

   logic                 step_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [BYTE_W-1:0]    rd_data;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [BYTE_W-1:0]    wr_data;
   result_type           result;

   // The held request advances when the response register is free or draining.
   assign step_en    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;
   assign csr_ready  = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= START_ADDRESS_RST;
         length_ff <= WINDOW_LENGTH_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_START_ADDRESS: start_ff  <= csr_data[START_W-1:0];
            CSR_WINDOW_LENGTH: length_ff <= csr_data[LENGTH_W-1:0];
            default: begin
               start_ff <= start_ff;
            end
         endcase
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         action_ff <= action_type'(req_tuser[1:0]);
         ferr_ff   <= req_tuser[2];
         byte_ff   <= req_tdata[7:0];
         ridx_ff   <= req_tdata[12:8];
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff};

   dmxswr_core #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .IDX_W        (IDX_W)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .action        (action_ff),
      .rx_byte       (byte_ff),
      .frame_error   (ferr_ff),
      .read_index    (ridx_ff),
      .start_address (start_ff),
      .window_length (length_ff),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .result        (result)
   );

   dmxswr_store #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .IDX_W        (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

endmodule
